FILE: hw/rtl/tbmc_pkg.sv
// Package for the two-button mode controller: word types, mode codes and constants.
// No dependencies.
package tbmc_pkg;

  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int CFG_BITS           = 16;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_WORK   = 2'd1;
  localparam logic [1:0] MODE_IDLE   = 2'd2;
  localparam logic [1:0] MODE_CONFIG = 2'd3;

  localparam logic [5:0] THR_MAX   = 6'd60;
  localparam logic [5:0] THR_STEP  = 6'd5;
  localparam logic [5:0] THR_RESET = 6'd50;

  localparam logic [CFG_BITS-1:0] COMPARE_RESET = 16'd19999;

  typedef struct packed {
    logic period_event;
    logic button_one_level;
    logic button_two_level;
  } tbmc_in_t;

  typedef struct packed {
    logic [1:0] system_mode;
    logic [5:0] alarm_threshold;
    logic       sensor_power;
    logic       cpu_wake;
    logic       buzzer_silence;
    logic       sample_timer_stop;
    logic       buttons_enabled;
  } tbmc_out_t;

endpackage

FILE: hw/rtl/tbmc_core.sv
// Mode, threshold and debounce state with the next-state logic for one word.
// Depends on tbmc_pkg.
module tbmc_core #(
  parameter int TIMER_BITS = tbmc_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  tbmc_pkg::tbmc_in_t            word,
  input  logic [tbmc_pkg::CFG_BITS-1:0] debounce_compare,
  output tbmc_pkg::tbmc_out_t           result
);
  import tbmc_pkg::*;

  logic [1:0]            mode_reg, mode_next;
  logic [5:0]            threshold_reg, threshold_next;
  logic                  button_one_busy, button_one_busy_next;
  logic                  button_two_busy, button_two_busy_next;
  logic                  button_one_last_level, button_two_last_level;
  logic                  enable_reg, enable_next;
  logic                  power_reg, power_next;
  logic [TIMER_BITS-1:0] debounce_count, debounce_count_next;

  logic [31:0]           cmp_ext;
  logic [TIMER_BITS-1:0] cmp_masked;
  logic                  match, rise1, rise2;
  logic                  wake, silence, stop, clear;

  // compare value seen through the timer width
  assign cmp_ext    = {{(32 - CFG_BITS){1'b0}}, debounce_compare};
  assign cmp_masked = cmp_ext[TIMER_BITS-1:0];
  assign match      = debounce_count == cmp_masked;
  assign rise1      = word.button_one_level && !button_one_last_level;
  assign rise2      = word.button_two_level && !button_two_last_level;

  always_comb begin
    mode_next            = mode_reg;
    threshold_next       = threshold_reg;
    button_one_busy_next = button_one_busy;
    button_two_busy_next = button_two_busy;
    enable_next          = enable_reg;
    power_next           = power_reg;
    wake                 = 1'b0;
    silence              = 1'b0;
    stop                 = 1'b0;
    clear                = 1'b0;

    if (word.period_event) begin
      power_next = 1'b1;
      if (mode_reg == MODE_START) begin
        mode_next = MODE_WORK;
        wake      = 1'b1;
      end else if (mode_reg == MODE_IDLE) begin
        mode_next   = MODE_WORK;
        enable_next = 1'b1;
        wake        = 1'b1;
      end
    end

    // debounce checks use the count held at the start of the clock
    if (match && button_one_busy) begin
      if (word.button_one_level) button_one_busy_next = 1'b0;
      else clear = 1'b1;
    end
    if (match && button_two_busy) begin
      if (word.button_two_level) button_two_busy_next = 1'b0;
      else clear = 1'b1;
    end

    if (rise1 && enable_next && !button_one_busy_next) begin
      stop       = 1'b1;
      power_next = 1'b0;
      if (mode_next == MODE_WORK || mode_next == MODE_IDLE) begin
        mode_next = MODE_CONFIG;
        wake      = 1'b1;
      end else begin
        enable_next = 1'b0;
        mode_next   = MODE_IDLE;
      end
      clear                = 1'b1;
      button_one_busy_next = 1'b1;
    end

    if (rise2 && enable_next && !button_two_busy_next) begin
      if (mode_next == MODE_WORK || mode_next == MODE_IDLE) begin
        silence = 1'b1;
      end else if (mode_next == MODE_CONFIG) begin
        threshold_next = (threshold_reg == THR_MAX) ? THR_STEP : threshold_reg + THR_STEP;
      end
      clear                = 1'b1;
      button_two_busy_next = 1'b1;
    end

    debounce_count_next = clear ? '0 : debounce_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg              <= MODE_START;
      threshold_reg         <= THR_RESET;
      button_one_busy       <= 1'b0;
      button_two_busy       <= 1'b0;
      button_one_last_level <= 1'b1;
      button_two_last_level <= 1'b1;
      enable_reg            <= 1'b1;
      power_reg             <= 1'b0;
      debounce_count        <= '0;
    end else if (accept) begin
      mode_reg              <= mode_next;
      threshold_reg         <= threshold_next;
      button_one_busy       <= button_one_busy_next;
      button_two_busy       <= button_two_busy_next;
      button_one_last_level <= word.button_one_level;
      button_two_last_level <= word.button_two_level;
      enable_reg            <= enable_next;
      power_reg             <= power_next;
      debounce_count        <= debounce_count_next;
    end
  end

  always_comb begin
    result.system_mode       = mode_next;
    result.alarm_threshold   = threshold_next;
    result.sensor_power      = power_next;
    result.cpu_wake          = wake;
    result.buzzer_silence    = silence;
    result.sample_timer_stop = stop;
    result.buttons_enabled   = enable_next;
  end

endmodule

FILE: hw/rtl/tbmc_out_reg.sv
// Result register with valid/stall handshake; takes a new word while the old one leaves.
// Depends on tbmc_pkg.
module tbmc_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tbmc_pkg::tbmc_out_t load_word,
  output logic                full_stalled,
  output logic                result_valid,
  input  logic                result_stall,
  output tbmc_pkg::tbmc_out_t result_word
);
  import tbmc_pkg::*;

  assign full_stalled = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_word <= load_word;
    end
  end

endmodule

FILE: hw/rtl/two_button_mode_controller.sv
// Two-button mode controller top level: config register, core state and result register.
// Depends on tbmc_pkg, tbmc_core, tbmc_out_reg.
// An accepted word's result word is computed combinationally and held in the result register from the next cycle.
// Throughput: one word per cycle while sample_stall is low; sample_stall only while a result waits under result_stall.
// Reset (rst, synchronous): mode start, threshold 50, buttons enabled, sensor off,
// debounce count 0, compare 19999, result register empty.
module two_button_mode_controller #(
  parameter int TIMER_BITS = tbmc_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  tbmc_pkg::tbmc_in_t            sample_word,
  output logic                          result_valid,
  input  logic                          result_stall,
  output tbmc_pkg::tbmc_out_t           result_word,
  input  logic                          cfg_we,
  input  logic [tbmc_pkg::CFG_BITS-1:0] cfg_wdata
);
  import tbmc_pkg::*;

  logic [CFG_BITS-1:0] debounce_compare;
  logic                accept;
  tbmc_out_t           core_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_compare <= COMPARE_RESET;
    end else if (cfg_we) begin
      debounce_compare <= cfg_wdata;
    end
  end

  assign accept = sample_valid && !sample_stall;

  tbmc_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .word             (sample_word),
    .debounce_compare (debounce_compare),
    .result           (core_result)
  );

  tbmc_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .load_word    (core_result),
    .full_stalled (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for two_button_mode_controller: directed table, then random button traffic.
// Depends on tbmc_pkg and the controller RTL; carries its own cycle-level model of the controller.
module tb_top;
  import tbmc_pkg::*;

  localparam int TIMER_W     = TIMER_BITS_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SQUEEZE_LEN = 60;

  typedef struct packed {
    tbmc_in_t  stim;
    logic      typed;
    tbmc_out_t want;
  } plan_row_t;

  localparam tbmc_out_t NO_CHECK = '0;

  logic                clk = 1'b0;
  logic                rst;
  logic                sample_valid;
  logic                sample_stall;
  tbmc_in_t            sample_word;
  logic                result_valid;
  logic                result_stall;
  tbmc_out_t           result_word;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;

  // controller model state
  logic [1:0]          pm_mode;
  logic [5:0]          pm_thr;
  logic                pm_busy1, pm_busy2;
  logic                pm_prev1, pm_prev2;
  logic                pm_enabled, pm_power;
  logic [TIMER_W-1:0]  pm_count;
  logic [CFG_BITS-1:0] pm_cmp;

  tbmc_out_t pending[$];
  tbmc_out_t want_word;
  plan_row_t plan [0:26];

  int mismatches   = 0;
  int results_seen = 0;
  int cycles       = 0;
  bit quiet        = 1'b0;
  bit squeeze_req  = 1'b0;
  bit lvl1 = 1'b1, lvl2 = 1'b1;
  int hold1 = 0, hold2 = 0;

  two_button_mode_controller DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_word  (sample_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // One timer clock of the controller; returns the word it produces.
  function automatic tbmc_out_t step_controller(tbmc_in_t w);
    logic rise1, rise2, wake, hush, stop, zero_count, hit;
    tbmc_out_t r;
    rise1      = w.button_one_level && !pm_prev1;
    rise2      = w.button_two_level && !pm_prev2;
    wake       = 1'b0;
    hush       = 1'b0;
    stop       = 1'b0;
    zero_count = 1'b0;
    hit        = (pm_count == TIMER_W'(pm_cmp));

    if (w.period_event) begin
      pm_power = 1'b1;
      if (pm_mode == MODE_START) begin
        pm_mode = MODE_WORK;
        wake    = 1'b1;
      end else if (pm_mode == MODE_IDLE) begin
        pm_mode    = MODE_WORK;
        pm_enabled = 1'b1;
        wake       = 1'b1;
      end
    end

    // debounce checks use the count held at the start of the clock
    if (hit && pm_busy1) begin
      if (w.button_one_level) pm_busy1 = 1'b0;
      else zero_count = 1'b1;
    end
    if (hit && pm_busy2) begin
      if (w.button_two_level) pm_busy2 = 1'b0;
      else zero_count = 1'b1;
    end

    if (rise1 && pm_enabled && !pm_busy1) begin
      stop     = 1'b1;
      pm_power = 1'b0;
      if (pm_mode == MODE_WORK || pm_mode == MODE_IDLE) begin
        pm_mode = MODE_CONFIG;
        wake    = 1'b1;
      end else begin
        pm_enabled = 1'b0;
        pm_mode    = MODE_IDLE;
      end
      zero_count = 1'b1;
      pm_busy1   = 1'b1;
    end

    if (rise2 && pm_enabled && !pm_busy2) begin
      if (pm_mode == MODE_WORK || pm_mode == MODE_IDLE)
        hush = 1'b1;
      else if (pm_mode == MODE_CONFIG)
        pm_thr = (pm_thr == THR_MAX) ? THR_STEP : pm_thr + THR_STEP;
      zero_count = 1'b1;
      pm_busy2   = 1'b1;
    end

    pm_count = zero_count ? '0 : pm_count + 1'b1;
    pm_prev1 = w.button_one_level;
    pm_prev2 = w.button_two_level;

    r.system_mode       = pm_mode;
    r.alarm_threshold   = pm_thr;
    r.sensor_power      = pm_power;
    r.cpu_wake          = wake;
    r.buzzer_silence    = hush;
    r.sample_timer_stop = stop;
    r.buttons_enabled   = pm_enabled;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    // keep the log bounded if the block is badly broken
    if (mismatches <= 100)
      $display("[%0t] word %0d %s: got %0d, want %0d", $time, results_seen, what, got, want);
  endtask

  // Offer one word from a falling edge; returns on the falling edge after acceptance.
  task automatic send_word(input tbmc_in_t w, input bit typed, input tbmc_out_t want);
    tbmc_out_t got;
    if (!quiet && $urandom_range(0, 99) < 10) begin
      sample_valid = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    sample_word  = w;
    sample_valid = 1'b1;
    do @(posedge clk); while (sample_stall);
    got = step_controller(w);
    pending.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic write_compare(input logic [CFG_BITS-1:0] v);
    sample_valid = 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    pm_cmp = v;
  endtask

  // Press/release traffic with hold times scaled to the debounce compare, plus some noise.
  task automatic run_random(input int n, input bit squeeze);
    tbmc_in_t w;
    int span;
    span = ((pm_cmp > 24) ? 24 : int'(pm_cmp)) + 4;
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == 40) begin
        squeeze_req = 1'b1;
        quiet       = 1'b1;
      end
      if (squeeze && i == 140) quiet = 1'b0;
      if ($urandom_range(0, 99) < 15) begin
        w = 3'($urandom_range(0, 7));
      end else begin
        if (hold1 == 0) begin
          lvl1  = !lvl1;
          hold1 = $urandom_range(1, span);
        end else hold1--;
        if (hold2 == 0) begin
          lvl2  = !lvl2;
          hold2 = $urandom_range(1, span);
        end else hold2--;
        w.period_event     = ($urandom_range(0, 15) == 0);
        w.button_one_level = lvl1;
        w.button_two_level = lvl2;
      end
      send_word(w, 1'b0, NO_CHECK);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want_word = pending.pop_front();
        if (result_word.system_mode !== want_word.system_mode)
          report_mismatch("system_mode", result_word.system_mode, want_word.system_mode);
        if (result_word.alarm_threshold !== want_word.alarm_threshold)
          report_mismatch("alarm_threshold", result_word.alarm_threshold,
                          want_word.alarm_threshold);
        if (result_word.sensor_power !== want_word.sensor_power)
          report_mismatch("sensor_power", result_word.sensor_power, want_word.sensor_power);
        if (result_word.cpu_wake !== want_word.cpu_wake)
          report_mismatch("cpu_wake", result_word.cpu_wake, want_word.cpu_wake);
        if (result_word.buzzer_silence !== want_word.buzzer_silence)
          report_mismatch("buzzer_silence", result_word.buzzer_silence,
                          want_word.buzzer_silence);
        if (result_word.sample_timer_stop !== want_word.sample_timer_stop)
          report_mismatch("sample_timer_stop", result_word.sample_timer_stop,
                          want_word.sample_timer_stop);
        if (result_word.buttons_enabled !== want_word.buttons_enabled)
          report_mismatch("buttons_enabled", result_word.buttons_enabled,
                          want_word.buttons_enabled);
      end
      results_seen++;
    end
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        result_stall = 1'b1;
        for (int c = 0; c < SQUEEZE_LEN; c++) @(negedge clk);
        squeeze_req  = 1'b0;
        result_stall = 1'b0;
      end else begin
        result_stall = !quiet && ($urandom_range(0, 99) < 10);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample_word  = '{1'b0, 1'b1, 1'b1};
    cfg_we       = 1'b0;
    cfg_wdata    = '0;

    pm_mode    = MODE_START;
    pm_thr     = THR_RESET;
    pm_busy1   = 1'b0;
    pm_busy2   = 1'b0;
    pm_prev1   = 1'b1;
    pm_prev2   = 1'b1;
    pm_enabled = 1'b1;
    pm_power   = 1'b0;
    pm_count   = '0;
    pm_cmp     = COMPARE_RESET;

    // traced with debounce compare 3; untyped rows go through the model
    plan = '{
      '{'{1'b0, 1'b1, 1'b1}, 1'b1, '{MODE_START, THR_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{1'b0, 1'b1, 1'b0}, 1'b1, '{MODE_START, THR_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      // button two in start only arms its debounce
      '{'{1'b0, 1'b1, 1'b1}, 1'b1, '{MODE_START, THR_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{1'b0, 1'b0, 1'b1}, 1'b1, '{MODE_START, THR_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      // button one in start: idle, buttons off, timer stop
      '{'{1'b0, 1'b1, 1'b1}, 1'b1, '{MODE_IDLE, THR_RESET, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
      // period in idle with buttons off re-enables them
      '{'{1'b1, 1'b1, 1'b1}, 1'b1, '{MODE_WORK, THR_RESET, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{'{1'b1, 1'b1, 1'b1}, 1'b1, '{MODE_WORK, THR_RESET, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{1'b0, 1'b0, 1'b1}, 1'b1, '{MODE_WORK, THR_RESET, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{1'b0, 1'b1, 1'b1}, 1'b1, '{MODE_CONFIG, THR_RESET, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
      '{'{1'b0, 1'b1, 1'b0}, 1'b1, '{MODE_CONFIG, THR_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{1'b0, 1'b1, 1'b1}, 1'b1, '{MODE_CONFIG, 6'd55, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{1'b1, 1'b1, 1'b1}, 1'b1, '{MODE_CONFIG, 6'd55, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
      // keep button two low through a debounce check, which restarts it, then press it again while busy
      '{'{1'b0, 1'b1, 1'b0}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b0}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b0}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b1}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b1}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b1}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b1}, 1'b0, NO_CHECK},
      // step to the top, then wrap to the bottom
      '{'{1'b0, 1'b1, 1'b0}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b1}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b1}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b1}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b1}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b1}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b0}, 1'b0, NO_CHECK},
      '{'{1'b0, 1'b1, 1'b1}, 1'b0, NO_CHECK}
    };

    repeat (12) @(negedge clk);
    rst = 1'b0;

    write_compare(16'd3);
    foreach (plan[k]) send_word(plan[k].stim, plan[k].typed, plan[k].want);

    write_compare(16'd0);
    run_random(150, 1'b0);
    write_compare(16'hFFFF);
    run_random(60, 1'b0);
    write_compare(16'd4);
    run_random(180, 1'b1);
    write_compare(CFG_BITS'($urandom_range(1, 15)));
    quiet = 1'b1;
    run_random(150, 1'b0);
    quiet = 1'b0;
    write_compare(COMPARE_RESET);
    run_random(60, 1'b0);

    sample_valid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
